FILE: hw/rtl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL converter package
// Widths, sector codes and inter-stage transaction records shared by the
// HSL to RGB pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

   localparam int unsigned HueWidth   = 9;
   localparam int unsigned PctWidth   = 7;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned SpanWidth  = 7;   // 100 - |2L - 100|, 0..100
   localparam int unsigned FoldWidth  = 6;   // 60 - |h mod 120 - 60|, 0..60
   localparam int unsigned ChromaWidth = 14; // span * S, 0..10000
   localparam int unsigned NumWidth   = 20;  // numerators over 600000
   localparam int unsigned ScaledWidth = 18; // (num * 17) >> 6
   localparam int unsigned ProdWidth  = 37;

   localparam logic [HueWidth-1:0] HueMax = 9'd359;
   localparam logic [PctWidth-1:0] PctMax = 7'd100;

   // ceil(2^28 / 625): exact floor(u / 625) for u below 2^18
   localparam logic [ProdWidth-1:0] RecipMul = 37'd429497;
   localparam int unsigned RecipShift = 28;

   typedef enum logic [5:0] {
      SEC_RED_YEL = 6'b000001,
      SEC_YEL_GRN = 6'b000010,
      SEC_GRN_CYN = 6'b000100,
      SEC_CYN_BLU = 6'b001000,
      SEC_BLU_MAG = 6'b010000,
      SEC_MAG_RED = 6'b100000
   } sector_type;

   typedef struct packed {
      logic                   valid;
      logic [ChromaWidth-1:0] chroma;
      logic [FoldWidth-1:0]   fold;
      logic [PctWidth-1:0]    light;
      sector_type             sector;
      logic [ByteWidth-1:0]   alpha;
   } front_type;

   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] val_c;
      logic [ByteWidth-1:0] val_x;
      logic [ByteWidth-1:0] val_m;
      sector_type           sector;
      logic [ByteWidth-1:0] alpha;
   } scale_type;

endpackage

`default_nettype wire

FILE: hw/rtl/hsl_front.sv
// ----------------------------------------------------------------------------
// HSL front end
// Clamps the inputs, folds the hue into its sector and distance term, and
// forms the chroma numerator. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [hsl_pkg::HueWidth-1:0]    hue_deg,
   input  logic [hsl_pkg::PctWidth-1:0]    sat_pct,
   input  logic [hsl_pkg::PctWidth-1:0]    light_pct,
   input  logic [hsl_pkg::ByteWidth-1:0]   alpha_in,
   output hsl_pkg::front_type              front_out
);
   import hsl_pkg::*;

   logic [HueWidth-1:0]  hue_sat;
   logic [PctWidth-1:0]  sat_sat;
   logic [PctWidth-1:0]  light_sat;
   logic [PctWidth:0]    light_dbl;
   logic [HueWidth-1:0]  hue_mod;
   logic [PctWidth-1:0]  hue_rem;

   logic                 valid1_ff, valid1_in;
   logic [SpanWidth-1:0] span1_ff, span1_in;
   logic [PctWidth-1:0]  sat1_ff;
   logic [PctWidth-1:0]  light1_ff;
   logic [FoldWidth-1:0] fold1_ff, fold1_in;
   sector_type           sector1_ff, sector1_in;
   logic [ByteWidth-1:0] alpha1_ff;

   front_type            front_ff, front_in;

   always_comb begin
      hue_sat   = (hue_deg > HueMax) ? HueMax : hue_deg;
      sat_sat   = (sat_pct > PctMax) ? PctMax : sat_pct;
      light_sat = (light_pct > PctMax) ? PctMax : light_pct;

      light_dbl = {light_sat, 1'b0};
      if (light_dbl >= 8'd100) begin
         span1_in = SpanWidth'(8'd200 - light_dbl);
      end else begin
         span1_in = light_dbl[SpanWidth-1:0];
      end

      // hue mod 120 and the sixty-degree sector
      priority if (hue_sat < 9'd60) begin
         sector1_in = SEC_RED_YEL;
      end else if (hue_sat < 9'd120) begin
         sector1_in = SEC_YEL_GRN;
      end else if (hue_sat < 9'd180) begin
         sector1_in = SEC_GRN_CYN;
      end else if (hue_sat < 9'd240) begin
         sector1_in = SEC_CYN_BLU;
      end else if (hue_sat < 9'd300) begin
         sector1_in = SEC_BLU_MAG;
      end else begin
         sector1_in = SEC_MAG_RED;
      end

      priority if (hue_sat < 9'd120) begin
         hue_mod = hue_sat;
      end else if (hue_sat < 9'd240) begin
         hue_mod = hue_sat - 9'd120;
      end else begin
         hue_mod = hue_sat - 9'd240;
      end
      hue_rem = hue_mod[PctWidth-1:0];

      if (hue_rem >= 7'd60) begin
         fold1_in = FoldWidth'(7'd120 - hue_rem);
      end else begin
         fold1_in = hue_rem[FoldWidth-1:0];
      end

      valid1_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
      end
      span1_ff   <= span1_in;
      sat1_ff    <= sat_sat;
      light1_ff  <= light_sat;
      fold1_ff   <= fold1_in;
      sector1_ff <= sector1_in;
      alpha1_ff  <= alpha_in;
   end

   always_comb begin
      front_in.valid  = valid1_ff;
      front_in.chroma = ChromaWidth'(span1_ff) * ChromaWidth'(sat1_ff);
      front_in.fold   = fold1_ff;
      front_in.light  = light1_ff;
      front_in.sector = sector1_ff;
      front_in.alpha  = alpha1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else begin
         front_ff.valid <= front_in.valid;
      end
      front_ff.chroma <= front_in.chroma;
      front_ff.fold   <= front_in.fold;
      front_ff.light  <= front_in.light;
      front_ff.sector <= front_in.sector;
      front_ff.alpha  <= front_in.alpha;
   end

   assign front_out = front_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/hsl_scale.sv
// ----------------------------------------------------------------------------
// HSL channel scaler
// Forms the C+M, X+M and M numerators, scales them by 255 and divides by
// the common denominator with a reciprocal multiply. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_scale (
   input  logic               clock,
   input  logic               reset,
   input  hsl_pkg::front_type front_in,
   output hsl_pkg::scale_type scale_out
);
   import hsl_pkg::*;

   // numerators are over 600000, the common denominator
   logic                  valid3_ff;
   logic [NumWidth-1:0]   num_c3_ff, num_c3_in;
   logic [NumWidth-1:0]   num_x3_ff, num_x3_in;
   logic [NumWidth-1:0]   num_m3_ff, num_m3_in;
   sector_type            sector3_ff;
   logic [ByteWidth-1:0]  alpha3_ff;

   logic                  valid4_ff;
   logic [ScaledWidth-1:0] u_c4_ff, u_c4_in;
   logic [ScaledWidth-1:0] u_x4_ff, u_x4_in;
   logic [ScaledWidth-1:0] u_m4_ff, u_m4_in;
   sector_type            sector4_ff;
   logic [ByteWidth-1:0]  alpha4_ff;

   logic [NumWidth:0]     light_term;
   logic [NumWidth:0]     chroma30;
   logic [NumWidth:0]     mix_x;
   logic [24:0]           t_c, t_x, t_m;
   logic [ProdWidth-1:0]  p_c, p_x, p_m;

   scale_type             scale_ff, scale_in;

   // stage 3: numerators
   always_comb begin
      light_term = (NumWidth+1)'(front_in.light) * 21'd6000;
      chroma30   = (NumWidth+1)'(front_in.chroma) * 21'd30;
      mix_x      = (NumWidth+1)'(front_in.chroma) * (NumWidth+1)'(front_in.fold)
                   + light_term - chroma30;
      num_c3_in  = NumWidth'(light_term + chroma30);
      num_m3_in  = NumWidth'(light_term - chroma30);
      num_x3_in  = mix_x[NumWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= front_in.valid;
      end
      num_c3_ff  <= num_c3_in;
      num_x3_ff  <= num_x3_in;
      num_m3_ff  <= num_m3_in;
      sector3_ff <= front_in.sector;
      alpha3_ff  <= front_in.alpha;
   end

   // stage 4: times 17, drop the power-of-two part of 40000
   always_comb begin
      t_c = 25'(num_c3_ff) * 25'd17;
      t_x = 25'(num_x3_ff) * 25'd17;
      t_m = 25'(num_m3_ff) * 25'd17;
      u_c4_in = t_c[ScaledWidth+5:6];
      u_x4_in = t_x[ScaledWidth+5:6];
      u_m4_in = t_m[ScaledWidth+5:6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= valid3_ff;
      end
      u_c4_ff    <= u_c4_in;
      u_x4_ff    <= u_x4_in;
      u_m4_ff    <= u_m4_in;
      sector4_ff <= sector3_ff;
      alpha4_ff  <= alpha3_ff;
   end

   // stage 5: divide by 625 through the reciprocal
   always_comb begin
      p_c = ProdWidth'(u_c4_ff) * RecipMul;
      p_x = ProdWidth'(u_x4_ff) * RecipMul;
      p_m = ProdWidth'(u_m4_ff) * RecipMul;
      scale_in.valid  = valid4_ff;
      scale_in.val_c  = p_c[RecipShift+ByteWidth-1:RecipShift];
      scale_in.val_x  = p_x[RecipShift+ByteWidth-1:RecipShift];
      scale_in.val_m  = p_m[RecipShift+ByteWidth-1:RecipShift];
      scale_in.sector = sector4_ff;
      scale_in.alpha  = alpha4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff.valid <= 1'b0;
      end else begin
         scale_ff.valid <= scale_in.valid;
      end
      scale_ff.val_c  <= scale_in.val_c;
      scale_ff.val_x  <= scale_in.val_x;
      scale_ff.val_m  <= scale_in.val_m;
      scale_ff.sector <= scale_in.sector;
      scale_ff.alpha  <= scale_in.alpha;
   end

   assign scale_out = scale_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Pipelined conversion of hue, saturation and lightness to 8-bit RGB with
// alpha passed through.
// ----------------------------------------------------------------------------
//
// The converter takes one transaction in every clock cycle: busy is always
// low, so each cycle with start high enters a new pixel. Each result appears
// on the rsp_ ports for exactly one cycle, marked by rsp_valid, once it has
// passed all pipeline stages, and in the same order. Since the receiver
// cannot stall, the six pipeline stages simply advance every cycle; nothing
// waits on the output side. The depth is set by the chroma multiply, the
// numerator multiply and the reciprocal multiply that replaces the division
// by the common denominator, each followed by its own register. Out-of-range
// hue saturates to 359 and saturation and lightness to 100. Reset flushes
// the pipeline: transactions in flight at reset are dropped.
//
`default_nettype none

module hsl_to_rgb_converter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [hsl_pkg::HueWidth-1:0]    req_hue_deg,
   input  logic [hsl_pkg::PctWidth-1:0]    req_sat_pct,
   input  logic [hsl_pkg::PctWidth-1:0]    req_light_pct,
   input  logic [hsl_pkg::ByteWidth-1:0]   req_alpha_in,
   output logic                            rsp_valid,
   output logic [hsl_pkg::ByteWidth-1:0]   rsp_red_out,
   output logic [hsl_pkg::ByteWidth-1:0]   rsp_green_out,
   output logic [hsl_pkg::ByteWidth-1:0]   rsp_blue_out,
   output logic [hsl_pkg::ByteWidth-1:0]   rsp_alpha_out
);
   import hsl_pkg::*;

   front_type            front;
   scale_type            scale;
   logic                 accept;

   logic                 valid_ff;
   logic [ByteWidth-1:0] red_ff, red_in;
   logic [ByteWidth-1:0] green_ff, green_in;
   logic [ByteWidth-1:0] blue_ff, blue_in;
   logic [ByteWidth-1:0] alpha_ff;

   // the pipeline never holds, so a transaction is taken whenever start is up
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // clamp, fold the hue, form chroma
   hsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .hue_deg   (req_hue_deg),
      .sat_pct   (req_sat_pct),
      .light_pct (req_light_pct),
      .alpha_in  (req_alpha_in),
      .front_out (front)
   );

   // channel numerators and scaling to bytes
   hsl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .front_in  (front),
      .scale_out (scale)
   );

   // route C+M, X+M and M to the channels by sixty-degree sector
   always_comb begin
      unique case (scale.sector)
         SEC_RED_YEL: begin
            red_in = scale.val_c; green_in = scale.val_x; blue_in = scale.val_m;
         end
         SEC_YEL_GRN: begin
            red_in = scale.val_x; green_in = scale.val_c; blue_in = scale.val_m;
         end
         SEC_GRN_CYN: begin
            red_in = scale.val_m; green_in = scale.val_c; blue_in = scale.val_x;
         end
         SEC_CYN_BLU: begin
            red_in = scale.val_m; green_in = scale.val_x; blue_in = scale.val_c;
         end
         SEC_BLU_MAG: begin
            red_in = scale.val_x; green_in = scale.val_m; blue_in = scale.val_c;
         end
         SEC_MAG_RED: begin
            red_in = scale.val_c; green_in = scale.val_m; blue_in = scale.val_x;
         end
         default: begin
            red_in = scale.val_c; green_in = scale.val_m; blue_in = scale.val_x;
         end
      endcase
   end

   // output register: one strobe per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= scale.valid;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      alpha_ff <= scale.alpha;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_alpha_out = alpha_ff;

`ifndef SYNTHESIS
   // every strobe traces back to an earlier transaction
   a_strobe_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 6))
      else $error("result strobe without a matching transaction");

   // alpha travels alongside the color data
   a_alpha_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alpha_out == $past(req_alpha_in, 6)))
      else $error("alpha misaligned with its transaction");

   // zero saturation gives gray
   a_gray_on_zero_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_sat_pct, 6) == 7'd0)) |->
         ((rsp_red_out == rsp_green_out) && (rsp_green_out == rsp_blue_out)))
      else $error("zero saturation did not give gray");

   // the C+M channel is never below the X+M channel, nor that below M
   a_channel_order: assert property (@(posedge clock) disable iff (reset)
      scale.valid |-> ((scale.val_c >= scale.val_x) && (scale.val_x >= scale.val_m)))
      else $error("channel magnitudes out of order");
`endif

endmodule

`default_nettype wire
